### rtl/core/i2cmbe_pkg.sv
// i2cmbe_pkg: shared types and constants for the i2c master byte engine
// no dependencies; imported by i2c_master_byte_engine_top and its testbench
package i2cmbe_pkg;

    localparam int RECOVER_PULSES_DEF = 9;

    typedef enum logic [2:0] {
        OP_START   = 3'd0,
        OP_STOP    = 3'd1,
        OP_WRITE   = 3'd2,
        OP_READ    = 3'd3,
        OP_RESTART = 3'd4,
        OP_RECOVER = 3'd5
    } t_op;

    typedef enum logic [4:0] {
        PH_IDLE          = 5'd0,
        PH_ST_CHECK      = 5'd1,
        PH_ST_SCL        = 5'd2,
        PH_ST_END        = 5'd3,
        PH_RS_REL        = 5'd4,
        PH_SP_REL_SCL    = 5'd5,
        PH_SP_REL_SDA    = 5'd6,
        PH_SP_END        = 5'd7,
        PH_WR_HIGH       = 5'd8,
        PH_WR_LOW        = 5'd9,
        PH_WR_ACK_HIGH   = 5'd10,
        PH_WR_ACK_SAMPLE = 5'd11,
        PH_RD_HIGH       = 5'd12,
        PH_RD_SAMPLE     = 5'd13,
        PH_RD_ACK_HIGH   = 5'd14,
        PH_RD_ACK_END    = 5'd15,
        PH_REC_REL       = 5'd16,
        PH_REC_EXIT      = 5'd17
    } t_phase;

endpackage

### rtl/core/i2c_master_byte_engine_top.sv
// i2c_master_byte_engine_top: open-drain i2c master, one half-bit tick per request
// the result of an accepted request is registered in the output register
// throughput: 1 request per cycle while the output is not stalled; the sequencer advances once per accepted tick
// a new request is taken while a result waits if that result is taken the same cycle
// reset (i_rst_n, synchronous): sequencer idle, line drives released, flags and rx byte zero
// depends on i2cmbe_pkg
module i2c_master_byte_engine_top
    import i2cmbe_pkg::*;
#(
    parameter int RECOVER_PULSES = RECOVER_PULSES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    // request channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_cmd_valid,
    input  logic [2:0] i_op,
    input  logic [7:0] i_tx_byte,
    input  logic       i_send_ack,
    input  logic       i_pin_a_level,
    input  logic       i_pin_b_level,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_pin_a_low,
    output logic       o_pin_b_low,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [7:0] o_rx_byte,
    output logic       o_ack_seen,
    output logic       o_start_blocked
);

    localparam logic [4:0] RecPulses = 5'(RECOVER_PULSES);

    logic       r_roles_swapped;
    t_phase     r_phase, n_phase;
    logic [3:0] r_bit_count, n_bit_count;
    logic [7:0] r_shift, n_shift;
    logic       r_ack_to_send, n_ack_to_send;
    logic       r_scl_drive, n_scl_drive;
    logic       r_sda_drive, n_sda_drive;
    logic       r_ack_flag, n_ack_flag;
    logic       r_blocked_flag, n_blocked_flag;
    logic [7:0] r_rx_hold, n_rx_hold;
    logic       n_done;

    logic       r_out_valid;
    logic       r_pin_a_low, r_pin_b_low, r_busy, r_done;

    logic       in_accept;
    logic       sda_level;
    logic [3:0] bit_inc;
    logic [4:0] bit_plus1;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign sda_level  = r_roles_swapped ? i_pin_a_level : i_pin_b_level;
    assign bit_inc    = r_bit_count + 4'd1;
    assign bit_plus1  = {1'b0, r_bit_count} + 5'd1;

    // sequencer: one segment per tick
    always_comb begin
        n_phase        = r_phase;
        n_bit_count    = r_bit_count;
        n_shift        = r_shift;
        n_ack_to_send  = r_ack_to_send;
        n_scl_drive    = r_scl_drive;
        n_sda_drive    = r_sda_drive;
        n_ack_flag     = r_ack_flag;
        n_blocked_flag = r_blocked_flag;
        n_rx_hold      = r_rx_hold;
        n_done         = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (i_cmd_valid && i_op <= OP_RECOVER) begin
                    case (t_op'(i_op))
                        OP_START: begin
                            n_sda_drive = 1'b0;
                            n_scl_drive = 1'b0;
                            n_phase     = PH_ST_CHECK;
                        end
                        OP_STOP: begin
                            n_sda_drive = 1'b1;
                            n_phase     = PH_SP_REL_SCL;
                        end
                        OP_WRITE: begin
                            n_shift     = i_tx_byte;
                            n_bit_count = 4'd7;
                            n_sda_drive = !i_tx_byte[7];
                            n_phase     = PH_WR_HIGH;
                        end
                        OP_READ: begin
                            n_ack_to_send = i_send_ack;
                            n_shift       = 8'd0;
                            n_bit_count   = 4'd8;
                            n_sda_drive   = 1'b0;
                            n_phase       = PH_RD_HIGH;
                        end
                        OP_RESTART: begin
                            n_sda_drive = 1'b0;
                            n_phase     = PH_RS_REL;
                        end
                        default: begin
                            // recovery: sda checked on the same tick; scl pulled low if sda is low, else released
                            n_bit_count = 4'd0;
                            if (!sda_level) begin
                                n_scl_drive = 1'b1;
                                n_phase     = PH_REC_REL;
                            end else begin
                                n_scl_drive = 1'b0;
                                n_sda_drive = 1'b1;
                                n_phase     = PH_SP_REL_SCL;
                            end
                        end
                    endcase
                end
            end
            PH_RS_REL: begin
                n_sda_drive = 1'b0;
                n_scl_drive = 1'b0;
                n_phase     = PH_ST_CHECK;
            end
            PH_ST_CHECK: begin
                if (!sda_level) begin
                    n_blocked_flag = 1'b1;
                    n_done         = 1'b1;
                    n_phase        = PH_IDLE;
                end else begin
                    n_sda_drive = 1'b1;
                    n_phase     = PH_ST_SCL;
                end
            end
            PH_ST_SCL: begin
                n_scl_drive = 1'b1;
                n_phase     = PH_ST_END;
            end
            PH_ST_END: begin
                n_blocked_flag = 1'b0;
                n_done         = 1'b1;
                n_phase        = PH_IDLE;
            end
            PH_SP_REL_SCL: begin
                n_scl_drive = 1'b0;
                n_phase     = PH_SP_REL_SDA;
            end
            PH_SP_REL_SDA: begin
                n_sda_drive = 1'b0;
                n_phase     = PH_SP_END;
            end
            PH_SP_END: begin
                n_done  = 1'b1;
                n_phase = PH_IDLE;
            end
            PH_WR_HIGH: begin
                n_scl_drive = 1'b0;
                n_phase     = PH_WR_LOW;
            end
            PH_WR_LOW: begin
                n_scl_drive = 1'b1;
                if (r_bit_count != 4'd0) begin
                    n_shift     = {r_shift[6:0], 1'b0};
                    n_bit_count = r_bit_count - 4'd1;
                    n_sda_drive = !r_shift[6];
                    n_phase     = PH_WR_HIGH;
                end else begin
                    n_sda_drive = 1'b0;
                    n_phase     = PH_WR_ACK_HIGH;
                end
            end
            PH_WR_ACK_HIGH: begin
                n_scl_drive = 1'b0;
                n_phase     = PH_WR_ACK_SAMPLE;
            end
            PH_WR_ACK_SAMPLE: begin
                n_ack_flag  = !sda_level;
                n_scl_drive = 1'b1;
                n_done      = 1'b1;
                n_phase     = PH_IDLE;
            end
            PH_RD_HIGH: begin
                n_scl_drive = 1'b0;
                n_phase     = PH_RD_SAMPLE;
            end
            PH_RD_SAMPLE: begin
                n_shift     = {r_shift[6:0], sda_level};
                n_scl_drive = 1'b1;
                n_bit_count = r_bit_count - 4'd1;
                if (r_bit_count != 4'd1) begin
                    n_phase = PH_RD_HIGH;
                end else begin
                    n_sda_drive = r_ack_to_send;
                    n_phase     = PH_RD_ACK_HIGH;
                end
            end
            PH_RD_ACK_HIGH: begin
                n_scl_drive = 1'b0;
                n_phase     = PH_RD_ACK_END;
            end
            PH_RD_ACK_END: begin
                n_scl_drive = 1'b1;
                n_sda_drive = 1'b0;
                n_rx_hold   = r_shift;
                n_done      = 1'b1;
                n_phase     = PH_IDLE;
            end
            PH_REC_REL: begin
                n_scl_drive = 1'b0;
                if (bit_plus1 >= RecPulses) begin
                    n_phase = PH_REC_EXIT;
                end else begin
                    n_bit_count = bit_inc;
                    if (!sda_level) begin
                        n_scl_drive = 1'b1;
                        n_phase     = PH_REC_REL;
                    end else begin
                        n_sda_drive = 1'b1;
                        n_phase     = PH_SP_REL_SCL;
                    end
                end
            end
            PH_REC_EXIT: begin
                n_sda_drive = 1'b1;
                n_phase     = PH_SP_REL_SCL;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roles_swapped <= 1'b0;
        end else if (i_cfg_we) begin
            r_roles_swapped <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_bit_count    <= 4'd0;
            r_shift        <= 8'd0;
            r_ack_to_send  <= 1'b0;
            r_scl_drive    <= 1'b0;
            r_sda_drive    <= 1'b0;
            r_ack_flag     <= 1'b0;
            r_blocked_flag <= 1'b0;
            r_rx_hold      <= 8'd0;
        end else if (in_accept) begin
            r_phase        <= n_phase;
            r_bit_count    <= n_bit_count;
            r_shift        <= n_shift;
            r_ack_to_send  <= n_ack_to_send;
            r_scl_drive    <= n_scl_drive;
            r_sda_drive    <= n_sda_drive;
            r_ack_flag     <= n_ack_flag;
            r_blocked_flag <= n_blocked_flag;
            r_rx_hold      <= n_rx_hold;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pin_a_low <= r_roles_swapped ? n_sda_drive : n_scl_drive;
            r_pin_b_low <= r_roles_swapped ? n_scl_drive : n_sda_drive;
            r_busy      <= (n_phase != PH_IDLE);
            r_done      <= n_done;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pin_a_low     = r_pin_a_low;
    assign o_pin_b_low     = r_pin_b_low;
    assign o_busy_res      = r_busy;
    assign o_done_res      = r_done;
    assign o_rx_byte       = r_rx_hold;
    assign o_ack_seen      = r_ack_flag;
    assign o_start_blocked = r_blocked_flag;

    // a completing request never reports busy
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res)
        else $error("done and busy reported together");

    // the shown busy flag tracks the sequencer until the next request
    a_busy_matches_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_busy_res == (r_phase != PH_IDLE)))
        else $error("busy result out of step with sequencer");

    // every accepted request leaves a result waiting
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_out_valid)
        else $error("accepted request produced no result");

    // read bit counter stays within one byte
    a_read_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_RD_HIGH || r_phase == PH_RD_SAMPLE)
            |-> (r_bit_count != 4'd0 && r_bit_count <= 4'd8))
        else $error("read bit counter out of range");

    // recovery pulse count never reaches the limit while pulsing
    a_recover_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_REC_REL |-> ({1'b0, r_bit_count} < RecPulses))
        else $error("recovery pulse count overrun");

endmodule

### sim/i2c_master_byte_engine_top_tb.sv
// i2c_master_byte_engine_top_tb: self-checking bench for the i2c master byte engine
// keeps its own copy of the half-bit sequencer and checks every tick result
// depends on i2cmbe_pkg and i2c_master_byte_engine_top
module i2c_master_byte_engine_top_tb;
    import i2cmbe_pkg::*;

    localparam logic [2:0] OP_RSVD_A = 3'd6;
    localparam logic [2:0] OP_RSVD_B = 3'd7;

    // how the test drives the data line level seen by the engine
    localparam int SDA_HIGH       = 0;
    localparam int SDA_LOW        = 1;
    localparam int SDA_RAND       = 2;
    localparam int SDA_MOSTLY_LOW = 3;

    localparam int STALL_NONE    = 0;
    localparam int STALL_RANDOM  = 1;
    localparam int STALL_PATTERN = 2;

    typedef struct packed {
        logic       pin_a_low;
        logic       pin_b_low;
        logic       busy;
        logic       done;
        logic [7:0] rx_byte;
        logic       ack_seen;
        logic       start_blocked;
    } t_tick_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_wdata = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic       i_cmd_valid = 1'b0;
    logic [2:0] i_op = 3'd0;
    logic [7:0] i_tx_byte = 8'd0;
    logic       i_send_ack = 1'b0;
    logic       i_pin_a_level = 1'b1;
    logic       i_pin_b_level = 1'b1;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic       o_pin_a_low;
    logic       o_pin_b_low;
    logic       o_busy_res;
    logic       o_done_res;
    logic [7:0] o_rx_byte;
    logic       o_ack_seen;
    logic       o_start_blocked;

    i2c_master_byte_engine_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd_valid    (i_cmd_valid),
        .i_op           (i_op),
        .i_tx_byte      (i_tx_byte),
        .i_send_ack     (i_send_ack),
        .i_pin_a_level  (i_pin_a_level),
        .i_pin_b_level  (i_pin_b_level),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pin_a_low    (o_pin_a_low),
        .o_pin_b_low    (o_pin_b_low),
        .o_busy_res     (o_busy_res),
        .o_done_res     (o_done_res),
        .o_rx_byte      (o_rx_byte),
        .o_ack_seen     (o_ack_seen),
        .o_start_blocked(o_start_blocked)
    );

    always #5 i_clk = ~i_clk;

    // sequencer copy
    logic       m_swap = 1'b0;
    t_phase     m_phase = PH_IDLE;
    logic [3:0] m_bits = 4'd0;
    logic [7:0] m_shift = 8'd0;
    logic       m_ack_tx = 1'b0;
    logic       m_scl = 1'b0;
    logic       m_sda = 1'b0;
    logic       m_ack = 1'b0;
    logic       m_blocked = 1'b0;
    logic [7:0] m_rx = 8'd0;

    t_tick_result tick_results_due[$];

    int n_errors = 0;
    int n_ticks = 0;
    int n_checked = 0;
    int n_cfg_writes = 0;
    int n_blocked = 0;
    int n_full_recover = 0;
    int cmds_taken[6] = '{default: 0};

    // sender idling
    int gap_max = 0;
    int burst_left = 0;

    // receiver stalling
    int         stall_mode = STALL_NONE;
    int         hold_req_id = 0;
    int         hold_req_len = 0;
    int         hold_ack_id = 0;
    int         hold_cnt = 0;
    logic [2:0] stall_step = 3'd0;
    localparam logic [7:0] STALL_SHAPE = 8'b1001_1100;

    // sda still low: pulse scl again, otherwise go to the stop
    function automatic void recovery_probe(input logic sda_lvl);
        if (!sda_lvl) begin
            m_scl = 1'b1;
            m_phase = PH_REC_REL;
        end else begin
            m_sda = 1'b1;
            m_phase = PH_SP_REL_SCL;
        end
    endfunction

    function automatic t_tick_result advance_engine(input logic cmdv, input logic [2:0] op,
                                                    input logic [7:0] tx, input logic sack,
                                                    input logic la, input logic lb);
        logic         sda_lvl;
        logic         done;
        t_tick_result r;
        sda_lvl = m_swap ? la : lb;
        done = 1'b0;
        case (m_phase)
            PH_IDLE: begin
                if (cmdv && op <= OP_RECOVER) begin
                    cmds_taken[op]++;
                    case (op)
                        OP_START: begin
                            m_sda = 1'b0;
                            m_scl = 1'b0;
                            m_phase = PH_ST_CHECK;
                        end
                        OP_STOP: begin
                            m_sda = 1'b1;
                            m_phase = PH_SP_REL_SCL;
                        end
                        OP_WRITE: begin
                            m_shift = tx;
                            m_bits = 4'd7;
                            m_sda = ~tx[7];
                            m_phase = PH_WR_HIGH;
                        end
                        OP_READ: begin
                            m_ack_tx = sack;
                            m_shift = 8'd0;
                            m_bits = 4'd8;
                            m_sda = 1'b0;
                            m_phase = PH_RD_HIGH;
                        end
                        OP_RESTART: begin
                            m_sda = 1'b0;
                            m_phase = PH_RS_REL;
                        end
                        default: begin
                            m_scl = 1'b0;
                            m_bits = 4'd0;
                            recovery_probe(sda_lvl);
                        end
                    endcase
                end
            end
            PH_RS_REL: begin
                m_sda = 1'b0;
                m_scl = 1'b0;
                m_phase = PH_ST_CHECK;
            end
            PH_ST_CHECK: begin
                if (!sda_lvl) begin
                    m_blocked = 1'b1;
                    done = 1'b1;
                    n_blocked++;
                    m_phase = PH_IDLE;
                end else begin
                    m_sda = 1'b1;
                    m_phase = PH_ST_SCL;
                end
            end
            PH_ST_SCL: begin
                m_scl = 1'b1;
                m_phase = PH_ST_END;
            end
            PH_ST_END: begin
                m_blocked = 1'b0;
                done = 1'b1;
                m_phase = PH_IDLE;
            end
            PH_SP_REL_SCL: begin
                m_scl = 1'b0;
                m_phase = PH_SP_REL_SDA;
            end
            PH_SP_REL_SDA: begin
                m_sda = 1'b0;
                m_phase = PH_SP_END;
            end
            PH_SP_END: begin
                done = 1'b1;
                m_phase = PH_IDLE;
            end
            PH_WR_HIGH: begin
                m_scl = 1'b0;
                m_phase = PH_WR_LOW;
            end
            PH_WR_LOW: begin
                m_scl = 1'b1;
                if (m_bits != 4'd0) begin
                    m_shift = {m_shift[6:0], 1'b0};
                    m_bits = m_bits - 4'd1;
                    m_sda = ~m_shift[7];
                    m_phase = PH_WR_HIGH;
                end else begin
                    m_sda = 1'b0;
                    m_phase = PH_WR_ACK_HIGH;
                end
            end
            PH_WR_ACK_HIGH: begin
                m_scl = 1'b0;
                m_phase = PH_WR_ACK_SAMPLE;
            end
            PH_WR_ACK_SAMPLE: begin
                m_ack = ~sda_lvl;
                m_scl = 1'b1;
                done = 1'b1;
                m_phase = PH_IDLE;
            end
            PH_RD_HIGH: begin
                m_scl = 1'b0;
                m_phase = PH_RD_SAMPLE;
            end
            PH_RD_SAMPLE: begin
                m_shift = {m_shift[6:0], sda_lvl};
                m_scl = 1'b1;
                m_bits = m_bits - 4'd1;
                if (m_bits != 4'd0) begin
                    m_phase = PH_RD_HIGH;
                end else begin
                    m_sda = m_ack_tx;
                    m_phase = PH_RD_ACK_HIGH;
                end
            end
            PH_RD_ACK_HIGH: begin
                m_scl = 1'b0;
                m_phase = PH_RD_ACK_END;
            end
            PH_RD_ACK_END: begin
                m_scl = 1'b1;
                m_sda = 1'b0;
                m_rx = m_shift;
                done = 1'b1;
                m_phase = PH_IDLE;
            end
            PH_REC_REL: begin
                m_scl = 1'b0;
                if (int'(m_bits) + 1 >= RECOVER_PULSES_DEF) begin
                    n_full_recover++;
                    m_phase = PH_REC_EXIT;
                end else begin
                    m_bits = m_bits + 4'd1;
                    recovery_probe(sda_lvl);
                end
            end
            PH_REC_EXIT: begin
                m_sda = 1'b1;
                m_phase = PH_SP_REL_SCL;
            end
            default: begin
                m_phase = PH_IDLE;
            end
        endcase
        r.pin_a_low = m_swap ? m_sda : m_scl;
        r.pin_b_low = m_swap ? m_scl : m_sda;
        r.busy = (m_phase != PH_IDLE);
        r.done = done;
        r.rx_byte = m_rx;
        r.ack_seen = m_ack;
        r.start_blocked = m_blocked;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        n_errors++;
        if (n_errors <= 30) begin
            $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
        end
    endtask

    // one request: a half-bit tick with the sampled pin levels and maybe a command
    task automatic send_tick(input logic cmdv, input logic [2:0] op, input logic [7:0] tx,
                             input logic sack, input int sda_mode);
        logic         sda_lvl;
        logic         scl_lvl;
        logic         la;
        logic         lb;
        t_tick_result r;
        if (gap_max > 0 && burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        case (sda_mode)
            SDA_HIGH:       sda_lvl = 1'b1;
            SDA_LOW:        sda_lvl = 1'b0;
            SDA_MOSTLY_LOW: sda_lvl = ($urandom_range(0, 7) == 0);
            default:        sda_lvl = $urandom_range(0, 1);
        endcase
        scl_lvl = $urandom_range(0, 1);
        la = m_swap ? sda_lvl : scl_lvl;
        lb = m_swap ? scl_lvl : sda_lvl;
        i_in_valid <= 1'b1;
        i_cmd_valid <= cmdv;
        i_op <= op;
        i_tx_byte <= tx;
        i_send_ack <= sack;
        i_pin_a_level <= la;
        i_pin_b_level <= lb;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        r = advance_engine(cmdv, op, tx, sack, la, lb);
        tick_results_due.push_back(r);
        n_ticks++;
        if (burst_left > 0) burst_left--;
    endtask

    // command tick, then ticks (with random commands if noisy) until the engine is idle again
    task automatic run_cmd(input logic [2:0] op, input logic [7:0] tx, input logic sack,
                           input int sda_mode, input bit noisy);
        send_tick(1'b1, op, tx, sack, sda_mode);
        while (m_phase != PH_IDLE) begin
            send_tick(noisy ? 1'($urandom_range(0, 1)) : 1'b0, 3'($urandom_range(0, 7)),
                      8'($urandom), 1'($urandom_range(0, 1)), sda_mode);
        end
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tick_results_due.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_roles(input logic swapped);
        wait_results_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= swapped;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        m_swap = swapped;
        n_cfg_writes++;
    endtask

    always @(posedge i_clk) begin
        if (hold_ack_id != hold_req_id) begin
            hold_cnt = hold_req_len;
            hold_ack_id = hold_req_id;
        end
        if (hold_cnt > 0) begin
            i_out_stall <= 1'b1;
            hold_cnt--;
        end else begin
            case (stall_mode)
                STALL_RANDOM: i_out_stall <= ($urandom_range(0, 99) < 35);
                STALL_PATTERN: begin
                    i_out_stall <= STALL_SHAPE[stall_step];
                    stall_step = stall_step + 3'd1;
                end
                default: i_out_stall <= 1'b0;
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_tick_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (tick_results_due.size() == 0) begin
                report_mismatch("unrequested result", 8'd0, 8'd0);
            end else begin
                want = tick_results_due.pop_front();
                n_checked++;
                if (o_pin_a_low !== want.pin_a_low)
                    report_mismatch("pin_a_low", 8'(o_pin_a_low), 8'(want.pin_a_low));
                if (o_pin_b_low !== want.pin_b_low)
                    report_mismatch("pin_b_low", 8'(o_pin_b_low), 8'(want.pin_b_low));
                if (o_busy_res !== want.busy)
                    report_mismatch("busy_res", 8'(o_busy_res), 8'(want.busy));
                if (o_done_res !== want.done)
                    report_mismatch("done_res", 8'(o_done_res), 8'(want.done));
                if (o_rx_byte !== want.rx_byte)
                    report_mismatch("rx_byte", o_rx_byte, want.rx_byte);
                if (o_ack_seen !== want.ack_seen)
                    report_mismatch("ack_seen", 8'(o_ack_seen), 8'(want.ack_seen));
                if (o_start_blocked !== want.start_blocked)
                    report_mismatch("start_blocked", 8'(o_start_blocked),
                                    8'(want.start_blocked));
            end
        end
    end

    task automatic test_directed_commands();
        run_cmd(OP_START, 8'h00, 1'b0, SDA_HIGH, 1'b0);
        run_cmd(OP_WRITE, 8'hFF, 1'b0, SDA_LOW, 1'b0);
        run_cmd(OP_WRITE, 8'h00, 1'b0, SDA_HIGH, 1'b0);
        run_cmd(OP_WRITE, 8'hA5, 1'b0, SDA_RAND, 1'b0);
        run_cmd(OP_READ, 8'h00, 1'b0, SDA_HIGH, 1'b0);
        run_cmd(OP_READ, 8'h00, 1'b1, SDA_LOW, 1'b0);
        // commands offered while busy must be dropped
        run_cmd(OP_RESTART, 8'h00, 1'b0, SDA_HIGH, 1'b1);
        run_cmd(OP_READ, 8'hFF, 1'b1, SDA_RAND, 1'b1);
        run_cmd(OP_STOP, 8'h00, 1'b0, SDA_RAND, 1'b1);
        // data line held low by a target
        run_cmd(OP_START, 8'h00, 1'b0, SDA_LOW, 1'b0);
        run_cmd(OP_RESTART, 8'h00, 1'b0, SDA_LOW, 1'b0);
        run_cmd(OP_RSVD_A, 8'hFF, 1'b1, SDA_RAND, 1'b0);
        run_cmd(OP_RSVD_B, 8'h00, 1'b0, SDA_RAND, 1'b0);
        send_tick(1'b0, OP_WRITE, 8'h5A, 1'b1, SDA_RAND);
        run_cmd(OP_RECOVER, 8'h00, 1'b0, SDA_LOW, 1'b0);
        run_cmd(OP_RECOVER, 8'h00, 1'b0, SDA_HIGH, 1'b0);
        run_cmd(OP_RECOVER, 8'h00, 1'b0, SDA_MOSTLY_LOW, 1'b0);
        run_cmd(OP_START, 8'h00, 1'b0, SDA_HIGH, 1'b0);
    endtask

    task automatic test_swapped_roles();
        set_roles(1'b1);
        run_cmd(OP_START, 8'h00, 1'b0, SDA_HIGH, 1'b0);
        run_cmd(OP_WRITE, 8'h7F, 1'b0, SDA_LOW, 1'b0);
        run_cmd(OP_READ, 8'h00, 1'b1, SDA_RAND, 1'b0);
        run_cmd(OP_START, 8'h00, 1'b0, SDA_LOW, 1'b0);
        run_cmd(OP_RECOVER, 8'h00, 1'b0, SDA_LOW, 1'b0);
        run_cmd(OP_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0);
    endtask

    // receiver holds off for a long time while requests keep coming
    task automatic test_backpressure();
        wait_results_drained();
        gap_max = 0;
        stall_mode = STALL_NONE;
        hold_req_len = 80;
        hold_req_id++;
        run_cmd(OP_START, 8'h00, 1'b0, SDA_HIGH, 1'b0);
        run_cmd(OP_WRITE, 8'($urandom), 1'b0, SDA_RAND, 1'b1);
        run_cmd(OP_READ, 8'h00, 1'b0, SDA_RAND, 1'b0);
        run_cmd(OP_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0);
        wait_results_drained();
    endtask

    // one bus transaction, mostly well formed, sometimes junk
    task automatic random_transaction();
        int  n_data;
        int  i;
        bit  noisy;
        bit  rd;
        noisy = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) < 12) begin
            case ($urandom_range(0, 4))
                0: run_cmd(3'($urandom_range(6, 7)), 8'($urandom), 1'($urandom_range(0, 1)),
                           SDA_RAND, 1'b0);
                1: repeat ($urandom_range(1, 3))
                       send_tick(1'b0, 3'($urandom_range(0, 7)), 8'($urandom),
                                 1'($urandom_range(0, 1)), SDA_RAND);
                2: run_cmd(OP_RECOVER, 8'($urandom), 1'b0, $urandom_range(0, 3), noisy);
                3: run_cmd(OP_STOP, 8'($urandom), 1'b0, SDA_RAND, noisy);
                default: run_cmd(3'($urandom_range(2, 3)), 8'($urandom),
                                 1'($urandom_range(0, 1)), SDA_RAND, noisy);
            endcase
        end else begin
            run_cmd(OP_START, 8'h00, 1'b0, ($urandom_range(0, 9) == 0) ? SDA_LOW : SDA_HIGH,
                    noisy);
            if (m_blocked) begin
                run_cmd(OP_RECOVER, 8'h00, 1'b0, $urandom_range(0, 3), noisy);
            end else begin
                rd = $urandom_range(0, 1);
                run_cmd(OP_WRITE, {7'($urandom), rd}, 1'b0, $urandom_range(0, 3), noisy);
                n_data = $urandom_range(0, 4);
                for (i = 0; i < n_data; i++) begin
                    if (rd)
                        run_cmd(OP_READ, 8'($urandom), 1'(i < n_data - 1), SDA_RAND, noisy);
                    else
                        run_cmd(OP_WRITE, 8'($urandom), 1'b0, $urandom_range(0, 3), noisy);
                end
                if ($urandom_range(0, 3) == 0) begin
                    run_cmd(OP_RESTART, 8'h00, 1'b0,
                            ($urandom_range(0, 7) == 0) ? SDA_LOW : SDA_HIGH, noisy);
                    if (!m_blocked) begin
                        run_cmd(OP_WRITE, 8'($urandom), 1'b0, SDA_MOSTLY_LOW, noisy);
                        run_cmd(OP_READ, 8'h00, 1'b0, SDA_RAND, noisy);
                    end
                end
                run_cmd(OP_STOP, 8'h00, 1'b0, SDA_RAND, noisy);
            end
        end
    endtask

    task automatic test_random_traffic(input logic swapped, input int stall_kind,
                                       input int gap_limit, input int quota);
        int stop_at;
        set_roles(swapped);
        stall_mode = stall_kind;
        gap_max = gap_limit;
        burst_left = 0;
        stop_at = n_ticks + quota;
        while (n_ticks < stop_at) random_transaction();
        wait_results_drained();
    endtask

    initial begin
        int guard;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_commands();
        test_swapped_roles();
        test_backpressure();
        test_random_traffic(1'b0, STALL_NONE, 0, 220);
        test_random_traffic(1'b1, STALL_RANDOM, 6, 230);
        test_random_traffic(1'b0, STALL_PATTERN, 3, 230);
        test_random_traffic(1'b1, STALL_RANDOM, 0, 230);
        i_in_valid <= 1'b0;
        guard = 0;
        while (tick_results_due.size() != 0 && guard < 10000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
        if (tick_results_due.size() != 0)
            report_mismatch("results never delivered", 8'(tick_results_due.size()), 8'd0);
        $display("ran %0d ticks, compared %0d results, %0d role writes, %0d blocked starts",
                 n_ticks, n_checked, n_cfg_writes, n_blocked);
        $display("start %0d stop %0d write %0d read %0d restart %0d recover %0d, %0d full",
                 cmds_taken[0], cmds_taken[1], cmds_taken[2], cmds_taken[3], cmds_taken[4],
                 cmds_taken[5], n_full_recover);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/core/i2cmbe_pkg.sv
rtl/core/i2c_master_byte_engine_top.sv
sim/i2c_master_byte_engine_top_tb.sv
